// ===== hw/rtl/mst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mst_pkg
// Types and codes shared by the software timer table and its slot cells.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam logic [2:0] MODE_CREATE = 3'd0;
	localparam logic [2:0] MODE_START  = 3'd1;
	localparam logic [2:0] MODE_STOP   = 3'd2;
	localparam logic [2:0] MODE_DELETE = 3'd3;
	localparam logic [2:0] MODE_TICK   = 3'd4;
	localparam logic [2:0] MODE_POLL   = 3'd5;

	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_FIRE = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [2:0]  slot_id;
		logic [31:0] interval;
		logic        repeat_flag;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        ok;
		logic [2:0]  result_slot;
		logic [31:0] now_ms;
		logic        last;
	} rsp_t;

	// command token walking down the row of slot cells
	typedef struct packed {
		logic        vld;
		logic [2:0]  mode;
		logic [2:0]  slot_id;
		logic [31:0] interval;
		logic        repeat_flag;
		logic        ok;
		logic [2:0]  slot;
	} tok_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mst_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mst_cell
// One timer slot. Applies the command token passing through it and hands the
// token on to the next cell.
// ----------------------------------------------------------------------------
module mst_cell
	import mst_pkg::*;
#(
	parameter int IDX = 0
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic [31:0] now,
	input  wire tok_t        tok_in,
	output tok_t             tok_out,
	output logic             fire
);

	localparam bit         ADDRESSABLE = (IDX < 8);
	localparam logic [2:0] IDX3        = 3'(IDX);

	logic        used_q;
	logic        running_q;
	logic        periodic_q;
	logic [31:0] period_q;
	logic [31:0] base_q;
	tok_t        tok_q;

	logic        hit;
	logic        expired;
	logic        do_create;
	logic        do_start;
	logic        do_stop;
	logic        do_delete;
	logic [31:0] elapsed;
	tok_t        tok_nxt;

	assign hit       = ADDRESSABLE && (tok_in.slot_id == IDX3) && used_q;
	assign elapsed   = now - base_q;
	assign expired   = elapsed >= period_q;

	assign do_create = tok_in.vld && (tok_in.mode == MODE_CREATE) && !tok_in.ok
		&& (tok_in.interval != 32'd0) && !used_q;
	assign do_start  = tok_in.vld && (tok_in.mode == MODE_START) && hit;
	assign do_stop   = tok_in.vld && (tok_in.mode == MODE_STOP) && hit;
	assign do_delete = tok_in.vld && (tok_in.mode == MODE_DELETE) && hit;
	assign fire      = tok_in.vld && (tok_in.mode == MODE_POLL) && used_q
		&& running_q && expired;

	always_comb begin
		tok_nxt = tok_in;
		if (do_create) begin
			tok_nxt.ok   = 1'b1;
			tok_nxt.slot = IDX3;
		end
		if (do_start || do_stop || do_delete) begin
			tok_nxt.ok = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= 1'b0;
			running_q  <= 1'b0;
			periodic_q <= 1'b0;
			period_q   <= '0;
			base_q     <= '0;
			tok_q      <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
			if (do_create) begin
				used_q     <= 1'b1;
				running_q  <= 1'b0;
				periodic_q <= tok_in.repeat_flag;
				period_q   <= tok_in.interval;
				base_q     <= '0;
			end
			if (do_start) begin
				base_q    <= now;
				running_q <= 1'b1;
			end
			if (do_stop) begin
				running_q <= 1'b0;
			end
			if (do_delete) begin
				running_q <= 1'b0;
				used_q    <= 1'b0;
			end
			if (fire) begin
				if (periodic_q) begin
					base_q <= base_q + period_q;
				end else begin
					running_q <= 1'b0;
				end
			end
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

// ===== hw/rtl/multi_slot_software_timer.sv =====
`default_nettype none
// Tick and unused mode codes: one result, valid in the cycle after transfer; one per cycle
// while the consumer takes each result. Create, start, stop, delete and poll: a token walks
// the row of slot cells, one cell per cycle unless stalled; the next request can transfer
// only once the final result has been loaded and the consumer can take it.
// A fire or final result waiting on a stalled consumer holds the token where it is.
// One command in flight at a time; reset clears the counter and all slots.
// ----------------------------------------------------------------------------
// multi_slot_software_timer
// Millisecond-driven timer table built as a row of slot cells.
// ----------------------------------------------------------------------------
module multi_slot_software_timer
	import mst_pkg::*;
#(
	parameter int NUM_SLOTS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int PW = $clog2(NUM_SLOTS + 1);

	logic [31:0]        millis_q;
	logic               busy_q;
	logic [PW-1:0]      pos_q;
	tok_t               head_q;
	logic               rsp_vld_q;
	rsp_t               rsp_q;

	tok_t               chain [NUM_SLOTS+1];
	logic [NUM_SLOTS-1:0] fire_vec;

	logic  fire_any;
	logic  tail_vld;
	logic  can_load;
	logic  adv;
	logic  take;
	logic  chained;

	assign chain[0] = head_q;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		mst_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.now     (millis_q),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1]),
			.fire    (fire_vec[i])
		);
	end

	assign fire_any  = |fire_vec;
	assign tail_vld  = chain[NUM_SLOTS].vld;
	assign can_load  = !rsp_vld_q || rsp_ready;
	assign adv       = !(fire_any || tail_vld) || can_load;
	assign req_ready = !busy_q && can_load;
	assign take      = req_valid && req_ready;
	assign chained   = (req.mode == MODE_CREATE) || (req.mode == MODE_START)
		|| (req.mode == MODE_STOP) || (req.mode == MODE_DELETE)
		|| (req.mode == MODE_POLL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			millis_q  <= '0;
			busy_q    <= 1'b0;
			pos_q     <= '0;
			head_q    <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (rsp_vld_q && rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
			if (take) begin
				pos_q <= '0;
				if (chained) begin
					busy_q             <= 1'b1;
					head_q.vld         <= 1'b1;
					head_q.mode        <= req.mode;
					head_q.slot_id     <= req.slot_id;
					head_q.interval    <= req.interval;
					head_q.repeat_flag <= req.repeat_flag;
					head_q.ok          <= 1'b0;
					head_q.slot        <= '0;
				end else begin
					rsp_vld_q <= 1'b1;
					if (req.mode == MODE_TICK) begin
						millis_q <= millis_q + 32'd1;
					end
				end
			end else if (adv) begin
				head_q.vld <= 1'b0;
				if (busy_q && !tail_vld) begin
					pos_q <= pos_q + PW'(1);
				end
			end
			if (busy_q && can_load && (fire_any || tail_vld)) begin
				rsp_vld_q <= 1'b1;
				if (tail_vld) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (take && !chained) begin
			rsp_q.kind        <= KIND_ACK;
			rsp_q.ok          <= (req.mode == MODE_TICK);
			rsp_q.result_slot <= '0;
			rsp_q.now_ms      <= (req.mode == MODE_TICK) ? millis_q + 32'd1 : millis_q;
			rsp_q.last        <= 1'b1;
		end else if (busy_q && can_load && fire_any) begin
			rsp_q.kind        <= KIND_FIRE;
			rsp_q.ok          <= 1'b1;
			rsp_q.result_slot <= 3'(pos_q);
			rsp_q.now_ms      <= millis_q;
			rsp_q.last        <= 1'b0;
		end else if (busy_q && can_load && tail_vld) begin
			rsp_q.now_ms <= millis_q;
			rsp_q.last   <= 1'b1;
			if (chain[NUM_SLOTS].mode == MODE_POLL) begin
				rsp_q.kind        <= KIND_DONE;
				rsp_q.ok          <= 1'b1;
				rsp_q.result_slot <= '0;
			end else begin
				rsp_q.kind        <= KIND_ACK;
				rsp_q.ok          <= chain[NUM_SLOTS].ok;
				rsp_q.result_slot <= chain[NUM_SLOTS].slot;
			end
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
